// ----- sv/cdw_pkg.sv -----
`timescale 1ns / 1ps

package cdw_pkg;

	localparam int COUNT_WIDTH_DEF = 8;
	localparam logic [7:0] DELAY_RESET = 8'd50;

	localparam int REQ_DATA_W = 16;
	localparam int RES_DATA_W = 16;
	localparam int KIND_W = 3;

	typedef enum logic [KIND_W-1:0] {
		KIND_NONE   = 3'd0,
		KIND_RAW    = 3'd1,
		KIND_CMD    = 3'd2,
		KIND_DATA   = 3'd3,
		KIND_CURSOR = 3'd4
	} kind_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [7:0]        payload;
		logic [1:0]        row;
		logic [4:0]        column;
		logic              busy_pin;
	} req_t;

	typedef struct packed {
		logic       reg_select;
		logic       read_write;
		logic       enable_pin;
		logic [3:0] nibble_out;
		logic       drive_data;
		logic       ready_res;
	} res_t;

	localparam logic [7:0] ROW_BASE_0 = 8'h80;
	localparam logic [7:0] ROW_BASE_1 = 8'hC0;
	localparam logic [7:0] ROW_BASE_2 = 8'h94;
	localparam logic [7:0] ROW_BASE_3 = 8'hD4;

	function automatic logic [7:0] row_base(input logic [1:0] row);
		logic [7:0] base;
		unique case (row)
			2'd0: base = ROW_BASE_0;
			2'd1: base = ROW_BASE_1;
			2'd2: base = ROW_BASE_2;
			default: base = ROW_BASE_3;
		endcase
		return base;
	endfunction

endpackage

// ----- sv/cdw_seq.sv -----
`timescale 1ns / 1ps

module cdw_seq #(
	parameter int COUNT_WIDTH = cdw_pkg::COUNT_WIDTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [7:0]    delay_ticks,
	input  logic          in_valid,
	input  cdw_pkg::req_t in_item,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output cdw_pkg::res_t out_res
);

	localparam int LW = ((COUNT_WIDTH > 8) ? COUNT_WIDTH : 8) + 1;

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_POLL_A_HI,
		PH_POLL_A_LO,
		PH_POLL_B_HI,
		PH_POLL_B_LO,
		PH_HI_NIB,
		PH_HI_GAP,
		PH_LO_NIB,
		PH_LO_GAP
	} phase_t;

	phase_t                 phase_q, phase_e, phase_n;
	logic [COUNT_WIDTH-1:0] tick_q, tick_e, tick_n;
	logic [7:0]             byte_q, byte_e;
	logic                   sel_q, sel_e;
	logic                   busy_q, busy_e, busy_n;
	logic                   valid_q;
	cdw_pkg::res_t          res_q, res_d;
	logic                   step;
	logic [LW-1:0]          dlen, cap, len, cnt_inc;

	assign step     = in_valid && (!valid_q || out_ready);
	assign in_ready = step;
	assign out_valid = valid_q;
	assign out_res   = res_q;

	always_comb begin
		cap  = LW'(1) << COUNT_WIDTH;
		dlen = (delay_ticks == 8'd0) ? LW'(1) : LW'(delay_ticks);
		if (dlen > cap) begin
			dlen = cap;
		end
	end

	always_comb begin
		phase_e = phase_q;
		tick_e  = tick_q;
		byte_e  = byte_q;
		sel_e   = sel_q;
		busy_e  = busy_q;
		res_d   = '0;

		if (phase_q == PH_IDLE) begin
			unique case (in_item.kind)
				cdw_pkg::KIND_RAW: begin
					res_d.ready_res = 1'b1;
					tick_e  = '0;
					busy_e  = 1'b0;
					byte_e  = {4'd0, in_item.payload[3:0]};
					sel_e   = 1'b0;
					phase_e = PH_LO_NIB;
				end
				cdw_pkg::KIND_CMD, cdw_pkg::KIND_DATA: begin
					res_d.ready_res = 1'b1;
					tick_e  = '0;
					busy_e  = 1'b0;
					byte_e  = in_item.payload;
					sel_e   = (in_item.kind == cdw_pkg::KIND_DATA);
					phase_e = PH_POLL_A_HI;
				end
				cdw_pkg::KIND_CURSOR: begin
					res_d.ready_res = 1'b1;
					tick_e  = '0;
					busy_e  = 1'b0;
					byte_e  = cdw_pkg::row_base(in_item.row) + {3'd0, in_item.column};
					sel_e   = 1'b0;
					phase_e = PH_POLL_A_HI;
				end
				default: begin
				end
			endcase
		end

		unique case (phase_e)
			PH_POLL_A_HI, PH_POLL_B_HI, PH_POLL_A_LO, PH_POLL_B_LO: begin
				res_d.reg_select = 1'b0;
				res_d.read_write = 1'b1;
				res_d.enable_pin = (phase_e == PH_POLL_A_HI) || (phase_e == PH_POLL_B_HI);
				res_d.nibble_out = 4'd0;
				res_d.drive_data = 1'b0;
			end
			PH_HI_NIB, PH_HI_GAP: begin
				res_d.reg_select = sel_e;
				res_d.read_write = 1'b0;
				res_d.enable_pin = (phase_e == PH_HI_NIB);
				res_d.nibble_out = byte_e[7:4];
				res_d.drive_data = 1'b1;
			end
			PH_LO_NIB, PH_LO_GAP: begin
				res_d.reg_select = sel_e;
				res_d.read_write = 1'b0;
				res_d.enable_pin = (phase_e == PH_LO_NIB);
				res_d.nibble_out = byte_e[3:0];
				res_d.drive_data = 1'b1;
			end
			default: begin
				res_d.reg_select = sel_e;
				res_d.read_write = 1'b0;
				res_d.enable_pin = 1'b0;
				res_d.nibble_out = byte_e[3:0];
				res_d.drive_data = 1'b1;
			end
		endcase

		len     = ((phase_e == PH_HI_GAP) || (phase_e == PH_LO_GAP)) ? LW'(1) : dlen;
		cnt_inc = LW'(tick_e) + LW'(1);
		phase_n = phase_e;
		tick_n  = tick_e;
		busy_n  = busy_e;
		if (phase_e != PH_IDLE) begin
			if (cnt_inc >= len) begin
				tick_n = '0;
				unique case (phase_e)
					PH_POLL_A_HI: begin
						busy_n  = in_item.busy_pin;
						phase_n = PH_POLL_A_LO;
					end
					PH_POLL_A_LO: phase_n = PH_POLL_B_HI;
					PH_POLL_B_HI: phase_n = PH_POLL_B_LO;
					PH_POLL_B_LO: phase_n = busy_e ? PH_POLL_A_HI : PH_HI_NIB;
					PH_HI_NIB:    phase_n = PH_HI_GAP;
					PH_HI_GAP:    phase_n = PH_LO_NIB;
					PH_LO_NIB:    phase_n = PH_LO_GAP;
					default:      phase_n = PH_IDLE;
				endcase
			end else begin
				tick_n = cnt_inc[COUNT_WIDTH-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			tick_q  <= '0;
			byte_q  <= '0;
			sel_q   <= 1'b0;
			busy_q  <= 1'b0;
			valid_q <= 1'b0;
			res_q   <= '0;
		end else begin
			if (step) begin
				phase_q <= phase_n;
				tick_q  <= tick_n;
				byte_q  <= byte_e;
				sel_q   <= sel_e;
				busy_q  <= busy_n;
				res_q   <= res_d;
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	a_accept_strobes: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && res_q.ready_res |-> res_q.enable_pin)
		else $error("accepted request does not start with E high");

	a_poll_reads: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !res_q.drive_data |-> res_q.read_write && !res_q.reg_select)
		else $error("data pins released outside a busy poll");

	a_idle_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_IDLE |-> tick_q == '0)
		else $error("tick count not cleared while idle");

	a_gap_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_HI_GAP || phase_q == PH_LO_GAP |-> tick_q == '0)
		else $error("gap phase lasted more than one tick");

	a_hold_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !out_ready |=> valid_q && $stable(res_q))
		else $error("result changed while stalled");

endmodule

// ----- sv/char_display_4bit_writer.sv -----
`timescale 1ns / 1ps

// Pin sequencer for a character display on a 4-bit bus. Every input transfer is one
// tick and yields exactly one output transfer with the RS, RW, E, D7..D4 and
// direction levels for that tick, one transfer per clock when both sides keep
// up; the result passes through the input register and then the result register.
// A request is taken only while the sequencer is idle, flagged by ready_res;
// commands, data bytes and cursor moves first poll the busy flag on D7, and
// each E phase lasts delay_ticks ticks (zero acts as one, capped at 2**COUNT_WIDTH).

module char_display_4bit_writer #(
	parameter int COUNT_WIDTH = cdw_pkg::COUNT_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [7:0]                     cfg_data,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// payload[7:0], row[9:8], column[14:10], busy_pin[15]
	input  logic [cdw_pkg::REQ_DATA_W-1:0] s_axis_tdata,
	// kind[2:0]
	input  logic [cdw_pkg::KIND_W-1:0]     s_axis_tuser,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// reg_select[0], read_write[1], enable_pin[2], nibble_out[6:3],
	// drive_data[7], ready_res[8], zeros above
	output logic [cdw_pkg::RES_DATA_W-1:0] m_axis_tdata
);

	logic          valid_s1;
	cdw_pkg::req_t item_s1;
	logic          seq_ready;
	logic [7:0]    delay_q;
	cdw_pkg::res_t res;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = !valid_s1 || seq_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q  <= cdw_pkg::DELAY_RESET;
			valid_s1 <= 1'b0;
		end else begin
			if (cfg_valid) begin
				delay_q <= cfg_data;
			end
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1.kind     <= s_axis_tuser;
			item_s1.payload  <= s_axis_tdata[7:0];
			item_s1.row      <= s_axis_tdata[9:8];
			item_s1.column   <= s_axis_tdata[14:10];
			item_s1.busy_pin <= s_axis_tdata[15];
		end
	end

	cdw_seq #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.delay_ticks(delay_q),
		.in_valid   (valid_s1),
		.in_item    (item_s1),
		.in_ready   (seq_ready),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_res    (res)
	);

	assign m_axis_tdata = {7'd0, res.ready_res, res.drive_data, res.nibble_out,
		res.enable_pin, res.read_write, res.reg_select};

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
	import cdw_pkg::*;

	localparam int KIND_LAST = (1 << KIND_W) - 1;
	localparam int DELAY_MAX = 255;

	typedef enum int {
		SEQ_IDLE,
		SEQ_POLL_A_HI,
		SEQ_POLL_A_LO,
		SEQ_POLL_B_HI,
		SEQ_POLL_B_LO,
		SEQ_HI_NIB,
		SEQ_HI_GAP,
		SEQ_LO_NIB,
		SEQ_LO_GAP
	} seq_step_t;

	class pin_scoreboard;
		res_t       pin_levels_due[$];
		seq_step_t  step_now;
		logic [8:0] tick_in_step;
		logic [7:0] byte_held;
		logic       select_held;
		logic       busy_latched;
		logic [7:0] delay_setting;
		int         mismatches;
		int         results_seen;

		function new();
			step_now = SEQ_IDLE;
			tick_in_step = '0;
			byte_held = '0;
			select_held = 1'b0;
			busy_latched = 1'b0;
			delay_setting = DELAY_RESET;
			mismatches = 0;
			results_seen = 0;
		endfunction

		function void set_delay(input logic [7:0] value);
			delay_setting = value;
		endfunction

		function bit sequencer_idle();
			return step_now == SEQ_IDLE;
		endfunction

		function logic [7:0] cursor_address(input logic [1:0] row, input logic [4:0] column);
			logic [7:0] base;
			case (row)
				2'd0: base = ROW_BASE_0;
				2'd1: base = ROW_BASE_1;
				2'd2: base = ROW_BASE_2;
				default: base = ROW_BASE_3;
			endcase
			return base + {3'b000, column};
		endfunction

		function void note_tick(input logic [KIND_W-1:0] kind, input logic [7:0] payload,
				input logic [1:0] row, input logic [4:0] column, input logic busy);
			res_t pins;
			logic [8:0] span;
			pins = '0;
			if (step_now == SEQ_IDLE && kind >= KIND_RAW && kind <= KIND_CURSOR) begin
				pins.ready_res = 1'b1;
				tick_in_step = '0;
				busy_latched = 1'b0;
				if (kind == KIND_RAW) begin
					byte_held = {4'h0, payload[3:0]};
					select_held = 1'b0;
					step_now = SEQ_LO_NIB;
				end else begin
					byte_held = (kind == KIND_CURSOR) ? cursor_address(row, column) : payload;
					select_held = (kind == KIND_DATA);
					step_now = SEQ_POLL_A_HI;
				end
			end
			case (step_now)
				SEQ_POLL_A_HI, SEQ_POLL_B_HI: begin
					pins.read_write = 1'b1;
					pins.enable_pin = 1'b1;
				end
				SEQ_POLL_A_LO, SEQ_POLL_B_LO: begin
					pins.read_write = 1'b1;
				end
				SEQ_HI_NIB, SEQ_HI_GAP: begin
					pins.reg_select = select_held;
					pins.enable_pin = (step_now == SEQ_HI_NIB);
					pins.nibble_out = byte_held[7:4];
					pins.drive_data = 1'b1;
				end
				default: begin
					pins.reg_select = select_held;
					pins.enable_pin = (step_now == SEQ_LO_NIB);
					pins.nibble_out = byte_held[3:0];
					pins.drive_data = 1'b1;
				end
			endcase
			if (step_now != SEQ_IDLE) begin
				if (step_now == SEQ_HI_GAP || step_now == SEQ_LO_GAP)
					span = 9'd1;
				else
					span = (delay_setting == 8'd0) ? 9'd1 : {1'b0, delay_setting};
				tick_in_step = tick_in_step + 9'd1;
				if (tick_in_step >= span) begin
					if (step_now == SEQ_POLL_A_HI)
						busy_latched = busy;
					if (step_now == SEQ_POLL_B_LO)
						step_now = busy_latched ? SEQ_POLL_A_HI : SEQ_HI_NIB;
					else if (step_now == SEQ_LO_GAP)
						step_now = SEQ_IDLE;
					else
						step_now = step_now.next();
					tick_in_step = '0;
				end
			end
			pin_levels_due.push_back(pins);
		endfunction

		task report_mismatch(input string what, input int got, input int want);
			mismatches++;
			$display("mismatch at result %0d: %s got %0h expected %0h",
				results_seen, what, got, want);
		endtask

		task check_result(input logic [RES_DATA_W-1:0] bus);
			res_t want;
			results_seen++;
			if (pin_levels_due.size() == 0) begin
				report_mismatch("unexpected transfer, tdata", int'(bus), 0);
			end else begin
				want = pin_levels_due.pop_front();
				if (bus[0] !== want.reg_select)
					report_mismatch("reg_select", int'(bus[0]), int'(want.reg_select));
				if (bus[1] !== want.read_write)
					report_mismatch("read_write", int'(bus[1]), int'(want.read_write));
				if (bus[2] !== want.enable_pin)
					report_mismatch("enable_pin", int'(bus[2]), int'(want.enable_pin));
				if (bus[6:3] !== want.nibble_out)
					report_mismatch("nibble_out", int'(bus[6:3]), int'(want.nibble_out));
				if (bus[7] !== want.drive_data)
					report_mismatch("drive_data", int'(bus[7]), int'(want.drive_data));
				if (bus[8] !== want.ready_res)
					report_mismatch("ready_res", int'(bus[8]), int'(want.ready_res));
				if (bus[RES_DATA_W-1:9] !== '0)
					report_mismatch("padding", int'(bus[RES_DATA_W-1:9]), 0);
			end
		endtask
	endclass

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic [7:0]              cfg_data;
	logic                    s_axis_tvalid;
	logic                    s_axis_tready;
	logic [REQ_DATA_W-1:0]   s_axis_tdata;
	logic [KIND_W-1:0]       s_axis_tuser;
	logic                    m_axis_tvalid;
	logic                    m_axis_tready;
	logic [RES_DATA_W-1:0]   m_axis_tdata;

	pin_scoreboard pins_sb;
	bit            steady_flow;
	bit            hold_off_request;
	int            hold_off_left;

	char_display_4bit_writer uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	initial begin
		#5000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		m_axis_tready = 1'b0;
		hold_off_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready)
				pins_sb.check_result(m_axis_tdata);
			if (hold_off_left > 0) begin
				hold_off_left--;
				m_axis_tready <= 1'b0;
			end else if (hold_off_request) begin
				hold_off_request = 1'b0;
				hold_off_left = 300;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= steady_flow ? 1'b1 : ($urandom_range(99) >= 34);
			end
		end
	end

	function automatic logic [KIND_W-1:0] KW5();
		return KIND_W'(int'(KIND_CURSOR) + 1);
	endfunction

	task drive_tick(input logic [KIND_W-1:0] kind, input logic [7:0] payload,
			input logic [1:0] row, input logic [4:0] column, input logic busy);
		while (!steady_flow && $urandom_range(99) < 34) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= kind;
		s_axis_tdata <= {busy, column, row, payload};
		do
			@(posedge clk);
		while (!s_axis_tready);
		pins_sb.note_tick(kind, payload, row, column, busy);
	endtask

	task drive_noise_tick(input logic [KIND_W-1:0] kind, input logic busy);
		drive_tick(kind, 8'($urandom), 2'($urandom), 5'($urandom), busy);
	endtask

	task run_request(input logic [KIND_W-1:0] kind, input logic [7:0] payload,
			input logic [1:0] row, input logic [4:0] column, input int busy_ticks);
		int n;
		n = 1;
		drive_tick(kind, payload, row, column, busy_ticks > 0);
		while (!pins_sb.sequencer_idle()) begin
			drive_noise_tick(KIND_NONE, n < busy_ticks);
			n++;
		end
	endtask

	task random_tick();
		int pick;
		logic [KIND_W-1:0] kind;
		pick = $urandom_range(99);
		if (pins_sb.sequencer_idle()) begin
			if (pick < 75)
				kind = KIND_W'($urandom_range(int'(KIND_CURSOR), int'(KIND_RAW)));
			else if (pick < 88)
				kind = KIND_NONE;
			else
				kind = KIND_W'($urandom_range(KIND_LAST, int'(KIND_CURSOR) + 1));
		end else begin
			if (pick < 85)
				kind = KIND_NONE;
			else if (pick < 95)
				kind = KIND_W'($urandom_range(int'(KIND_CURSOR), int'(KIND_RAW)));
			else
				kind = KIND_W'($urandom_range(KIND_LAST, int'(KIND_CURSOR) + 1));
		end
		drive_noise_tick(kind, $urandom_range(99) < 25);
	endtask

	task wait_drained();
		while (pins_sb.pin_levels_due.size() != 0)
			@(posedge clk);
	endtask

	task write_delay(input logic [7:0] value);
		while (!pins_sb.sequencer_idle())
			drive_noise_tick(KIND_NONE, 1'b0);
		s_axis_tvalid <= 1'b0;
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		pins_sb.set_delay(value);
	endtask

	task random_run(input int ticks);
		repeat (ticks)
			random_tick();
	endtask

	initial begin
		pins_sb = new();
		steady_flow = 1'b0;
		hold_off_request = 1'b0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = KIND_NONE;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset delay first, so the default setting sees some traffic.
		random_run(150);

		write_delay(8'd1);
		run_request(KIND_RAW, 8'hF5, 2'd0, 5'd0, 0);
		run_request(KIND_RAW, 8'hAF, 2'd3, 5'd31, 0);
		run_request(KIND_RAW, 8'h50, 2'd0, 5'd0, 0);
		run_request(KIND_CMD, 8'h00, 2'd0, 5'd0, 0);
		run_request(KIND_CMD, 8'hFF, 2'd0, 5'd0, 6);
		run_request(KIND_DATA, 8'hA5, 2'd0, 5'd0, 0);
		run_request(KIND_DATA, 8'h5A, 2'd0, 5'd0, 2);
		run_request(KIND_CURSOR, 8'h00, 2'd0, 5'd0, 0);
		run_request(KIND_CURSOR, 8'hFF, 2'd1, 5'd31, 0);
		run_request(KIND_CURSOR, 8'h00, 2'd2, 5'd17, 0);
		run_request(KIND_CURSOR, 8'hFF, 2'd3, 5'd31, 0);
		drive_tick(KW5(), 8'hFF, 2'd3, 5'd31, 1'b1);
		drive_tick(KIND_W'(KIND_LAST), 8'hFF, 2'd3, 5'd31, 1'b1);
		drive_tick(KIND_NONE, 8'hFF, 2'd3, 5'd31, 1'b1);
		drive_tick(KIND_CMD, 8'h3C, 2'd0, 5'd0, 1'b0);
		run_request(KIND_DATA, 8'hFF, 2'd1, 5'd1, 0);

		random_run(150);
		hold_off_request = 1'b1;
		random_run(150);
		s_axis_tvalid <= 1'b0;
		wait_drained();
		random_run(150);

		write_delay(8'd0);
		steady_flow = 1'b1;
		random_run(200);
		steady_flow = 1'b0;

		write_delay(8'd2);
		random_run(150);

		write_delay(8'($urandom_range(8, 3)));
		random_run(150);

		write_delay(8'(DELAY_MAX));
		random_run(300);

		write_delay(8'd1);
		random_run(100);

		s_axis_tvalid <= 1'b0;
		wait_drained();
		repeat (10) @(posedge clk);
		if (pins_sb.mismatches == 0 && pins_sb.pin_levels_due.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ----- filelist.f -----
sv/cdw_pkg.sv
sv/cdw_seq.sv
sv/char_display_4bit_writer.sv
verif/testbench.sv
